[hdl/btx_pkg.sv]
// Shared types and constants for the binary trie max-xor unit.
package btx_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int PLEN_W  = 6;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_ERASE  = 3'd1,
        ACT_GET    = 3'd2,
        ACT_COUNT  = 3'd3,
        ACT_MAXX   = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_LEAF,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_STEP,
        CMD_LEAF,
        CMD_PUSH
    } t_cmd;

    typedef struct packed {
        t_cmd op;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic walk_end;
        logic restart;
        logic need_leaf;
    } t_dp_sts;

endpackage

[hdl/btx_req_if.sv]
// Request channel: one trie action item.
interface btx_req_if;
    import btx_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value_in;
    logic [PLEN_W-1:0] prefix_len;

    modport source (output valid, action, key, value_in, prefix_len, input ready);
    modport sink   (input valid, action, key, value_in, prefix_len, output ready);
endinterface

[hdl/btx_rsp_if.sv]
// Response channel: one trie result item.
interface btx_rsp_if;
    import btx_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value_out;
    logic [KEY_W-1:0]  best_key;
    logic [CNT_W-1:0]  prefix_count;

    modport source (output valid, status, value_out, best_key, prefix_count, input ready);
    modport sink   (input valid, status, value_out, best_key, prefix_count, output ready);
endinterface

[hdl/btx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module btx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/btx_ctrl.sv]
// Sequencer for clearing, walking passes, leaf reads and result hand-off.
module btx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output btx_pkg::t_dp_cmd o_cmd,
    input  btx_pkg::t_dp_sts i_sts
);
    import btx_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = CMD_NONE;
        o_req_ready = 1'b0;
        n_out_vld   = r_out_vld && !i_rsp_ready;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = CMD_CLEAR;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.op = CMD_STEP;
                if (i_sts.walk_end) begin
                    priority if (i_sts.restart) begin
                        n_state = S_WALK;
                    end else if (i_sts.need_leaf) begin
                        n_state = S_LEAF;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LEAF: begin
                o_cmd.op = CMD_LEAF;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_vld || i_rsp_ready) begin
                    o_cmd.op  = CMD_PUSH;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_rsp_valid = r_out_vld;
endmodule

[hdl/btx_dp.sv]
// Trie datapath: node and count memories, walk registers and result registers.
module btx_dp #(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096,
    parameter int VALUE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  btx_pkg::t_dp_cmd           i_cmd,
    output btx_pkg::t_dp_sts           o_sts,
    input  logic [btx_pkg::ACT_W-1:0]  i_action,
    input  logic [btx_pkg::KEY_W-1:0]  i_key,
    input  logic [btx_pkg::VAL_W-1:0]  i_value_in,
    input  logic [btx_pkg::PLEN_W-1:0] i_prefix_len,
    output logic [btx_pkg::STAT_W-1:0] o_status,
    output logic [btx_pkg::VAL_W-1:0]  o_value_out,
    output logic [btx_pkg::KEY_W-1:0]  o_best_key,
    output logic [btx_pkg::CNT_W-1:0]  o_prefix_count
);
    import btx_pkg::*;

    localparam int LW  = $clog2(NODE_COUNT);
    localparam int FW  = $clog2(NODE_COUNT + 1);
    localparam int LVW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    // Walk and result registers
    logic [ACT_W-1:0]      r_act;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [LW-1:0]         r_node, n_node;
    logic [LVW-1:0]        r_lvl, n_lvl;
    logic [LVW-1:0]        r_stop;
    logic                  r_pz;
    logic                  r_pass, n_pass;
    logic [STAT_W-1:0]     r_stat, n_stat;
    logic [KEY_BITS-1:0]   r_best, n_best;
    logic [CNT_W-1:0]      r_pcnt, n_pcnt;
    logic [VALUE_BITS-1:0] r_vout;
    logic [FW-1:0]         r_free, n_free;
    logic [LW-1:0]         r_clr;

    // Memory ports
    logic                  ch_we, ed_we, lf_we;
    logic [LW-1:0]         row_waddr, rd_addr, lf_waddr, lf_raddr;
    logic [2*LW-1:0]       ch_wdata, ch_rd;
    logic [2*CNT_W-1:0]    ed_wdata, ed_rd;
    logic [VALUE_BITS-1:0] lf_wdata, lf_rd;

    // Per-level decode
    logic                  b, last;
    logic [LW-1:0]         ch0, ch1, ch_s, ch_o, new_lk, nxt;
    logic [CNT_W-1:0]      c0, c1, cnt_s, cnt_inc, cnt_dec;
    logic [CNT_W:0]        sum01;
    logic [FW:0]           need_tot;
    logic                  fit, pick_o;

    // Load-time helpers
    logic [KEY_BITS+KEY_W-1:0]   key_x;
    logic [VALUE_BITS+VAL_W-1:0] val_x;
    logic [6:0]                  plen7, plen_n, stop7;
    logic [KEY_BITS+KEY_W-1:0]   best_x;
    logic [VALUE_BITS+VAL_W-1:0] vout_x, lf_x;

    btx_ram #(.WIDTH(2*LW), .DEPTH(NODE_COUNT)) u_child (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(row_waddr), .i_wdata(ch_wdata),
        .i_raddr(rd_addr), .o_rdata(ch_rd)
    );
    btx_ram #(.WIDTH(2*CNT_W), .DEPTH(NODE_COUNT)) u_count (
        .i_clk(i_clk), .i_we(ed_we), .i_waddr(row_waddr), .i_wdata(ed_wdata),
        .i_raddr(rd_addr), .o_rdata(ed_rd)
    );
    btx_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODE_COUNT)) u_leaf (
        .i_clk(i_clk), .i_we(lf_we), .i_waddr(lf_waddr), .i_wdata(lf_wdata),
        .i_raddr(lf_raddr), .o_rdata(lf_rd)
    );

    // Decode the row of the current node
    assign ch0     = ch_rd[LW-1:0];
    assign ch1     = ch_rd[2*LW-1:LW];
    assign c0      = ed_rd[CNT_W-1:0];
    assign c1      = ed_rd[2*CNT_W-1:CNT_W];
    assign b       = r_key[r_lvl];
    assign last    = (r_lvl == '0);
    assign ch_s    = b ? ch1 : ch0;
    assign ch_o    = b ? ch0 : ch1;
    assign cnt_s   = b ? c1 : c0;
    assign cnt_inc = (cnt_s == CNT_MAX) ? cnt_s : cnt_s + 1'b1;
    assign cnt_dec = (cnt_s != '0) ? cnt_s - 1'b1 : cnt_s;
    assign sum01   = {1'b0, c0} + {1'b0, c1};
    assign need_tot = {1'b0, r_free} + (FW+1)'(r_lvl) + 1'b1;
    assign fit     = (need_tot <= (FW+1)'(NODE_COUNT));
    assign new_lk  = (ch_s == '0) ? r_free[LW-1:0] : ch_s;
    assign pick_o  = (ch_o != '0);
    assign nxt     = pick_o ? ch_o : ch_s;

    // Fit input fields to the configured widths
    assign key_x  = {{KEY_BITS{1'b0}}, i_key};
    assign val_x  = {{VALUE_BITS{1'b0}}, i_value_in};
    assign plen7  = {1'b0, i_prefix_len};
    assign plen_n = (plen7 > 7'(KEY_BITS)) ? 7'(KEY_BITS) : plen7;
    assign stop7  = 7'(KEY_BITS) - plen_n;

    // Step logic: one trie level per cycle
    always_comb begin
        n_node    = r_node;
        n_lvl     = r_lvl;
        n_pass    = r_pass;
        n_stat    = r_stat;
        n_best    = r_best;
        n_pcnt    = r_pcnt;
        n_free    = r_free;
        rd_addr   = '0;
        row_waddr = r_node;
        ch_we     = 1'b0;
        ed_we     = 1'b0;
        lf_we     = 1'b0;
        ch_wdata  = ch_rd;
        ed_wdata  = ed_rd;
        lf_waddr  = new_lk;
        lf_wdata  = r_val;
        lf_raddr  = ch_s;
        o_sts     = '0;

        unique case (i_cmd.op)
            CMD_CLEAR: begin
                row_waddr = r_clr;
                lf_waddr  = r_clr;
                ch_we     = 1'b1;
                ed_we     = 1'b1;
                lf_we     = 1'b1;
                ch_wdata  = '0;
                ed_wdata  = '0;
                lf_wdata  = '0;
                o_sts.clear_done = (r_clr == LW'(NODE_COUNT - 1));
            end
            CMD_STEP: begin
                unique case (r_act)
                    ACT_INSERT: begin
                        if (!r_pass) begin
                            if (ch_s == '0 || last) begin
                                o_sts.walk_end = 1'b1;
                                if (ch_s == '0 && !fit) begin
                                    n_stat = ST_FULL;
                                end else begin
                                    o_sts.restart = 1'b1;
                                end
                            end else begin
                                n_node  = ch_s;
                                n_lvl   = r_lvl - 1'b1;
                                rd_addr = ch_s;
                            end
                        end else begin
                            // link a fresh node where the path is missing
                            if (ch_s == '0) begin
                                n_free = r_free + 1'b1;
                            end
                            ch_we    = 1'b1;
                            ed_we    = 1'b1;
                            ch_wdata = b ? {new_lk, ch0} : {ch1, new_lk};
                            ed_wdata = b ? {cnt_inc, c0} : {c1, cnt_inc};
                            if (last) begin
                                lf_we          = 1'b1;
                                o_sts.walk_end = 1'b1;
                            end else begin
                                n_node  = new_lk;
                                n_lvl   = r_lvl - 1'b1;
                                rd_addr = new_lk;
                            end
                        end
                    end
                    ACT_ERASE: begin
                        if (!r_pass) begin
                            if (ch_s == '0) begin
                                o_sts.walk_end = 1'b1;
                                n_stat         = ST_MISS;
                            end else if (last) begin
                                o_sts.walk_end = 1'b1;
                                o_sts.restart  = 1'b1;
                            end else begin
                                n_node  = ch_s;
                                n_lvl   = r_lvl - 1'b1;
                                rd_addr = ch_s;
                            end
                        end else begin
                            // drop one count per edge, unlink edges that empty
                            ch_we    = 1'b1;
                            ed_we    = 1'b1;
                            ed_wdata = b ? {cnt_dec, c0} : {c1, cnt_dec};
                            if (cnt_dec == '0) begin
                                ch_wdata = b ? {LW'(0), ch0} : {ch1, LW'(0)};
                            end
                            if (last) begin
                                lf_waddr       = ch_s;
                                lf_wdata       = '0;
                                lf_we          = (cnt_dec == '0);
                                o_sts.walk_end = 1'b1;
                            end else begin
                                n_node  = ch_s;
                                n_lvl   = r_lvl - 1'b1;
                                rd_addr = ch_s;
                            end
                        end
                    end
                    ACT_GET: begin
                        if (ch_s == '0) begin
                            o_sts.walk_end = 1'b1;
                            n_stat         = ST_MISS;
                        end else if (last) begin
                            o_sts.walk_end  = 1'b1;
                            o_sts.need_leaf = 1'b1;
                        end else begin
                            n_node  = ch_s;
                            n_lvl   = r_lvl - 1'b1;
                            rd_addr = ch_s;
                        end
                    end
                    ACT_COUNT: begin
                        if (r_pz) begin
                            o_sts.walk_end = 1'b1;
                            n_pcnt = sum01[CNT_W] ? CNT_MAX : sum01[CNT_W-1:0];
                        end else if (ch_s == '0) begin
                            o_sts.walk_end = 1'b1;
                            n_pcnt         = '0;
                        end else begin
                            n_pcnt = cnt_s;
                            if (r_lvl == r_stop) begin
                                o_sts.walk_end = 1'b1;
                            end else begin
                                n_node  = ch_s;
                                n_lvl   = r_lvl - 1'b1;
                                rd_addr = ch_s;
                            end
                        end
                    end
                    ACT_MAXX: begin
                        // prefer the branch with the opposite bit
                        if (ch_o == '0 && ch_s == '0) begin
                            o_sts.walk_end = 1'b1;
                            n_stat         = ST_MISS;
                            n_best         = '0;
                        end else begin
                            n_best[r_lvl] = pick_o ? ~b : b;
                            lf_raddr      = nxt;
                            if (last) begin
                                o_sts.walk_end  = 1'b1;
                                o_sts.need_leaf = 1'b1;
                            end else begin
                                n_node  = nxt;
                                n_lvl   = r_lvl - 1'b1;
                                rd_addr = nxt;
                            end
                        end
                    end
                    default: o_sts.walk_end = 1'b1;
                endcase
                if (o_sts.restart) begin
                    n_node  = '0;
                    n_lvl   = LVW'(KEY_BITS - 1);
                    n_pass  = 1'b1;
                    rd_addr = '0;
                end
            end
            default: ;
        endcase
    end

    // Control registers: clear sweep and node allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_free <= FW'(1);
        end else begin
            if (i_cmd.op == CMD_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            r_free <= n_free;
        end
    end

    assign lf_x = {{VAL_W{1'b0}}, lf_rd};

    // Item and walk registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_act  <= i_action;
                r_key  <= key_x[KEY_BITS-1:0];
                r_val  <= val_x[VALUE_BITS-1:0];
                r_pz   <= (plen_n == '0);
                r_stop <= stop7[LVW-1:0];
                r_node <= '0;
                r_lvl  <= LVW'(KEY_BITS - 1);
                r_pass <= 1'b0;
                r_stat <= ST_OK;
                r_best <= '0;
                r_pcnt <= '0;
                r_vout <= '0;
            end
            CMD_STEP: begin
                r_node <= n_node;
                r_lvl  <= n_lvl;
                r_pass <= n_pass;
                r_stat <= n_stat;
                r_best <= n_best;
                r_pcnt <= n_pcnt;
            end
            CMD_LEAF: begin
                r_vout <= lf_x[VALUE_BITS-1:0];
            end
            default: ;
        endcase
    end

    assign best_x = {{KEY_W{1'b0}}, r_best};
    assign vout_x = {{VAL_W{1'b0}}, r_vout};

    // Output register, loaded when the result is handed off
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_PUSH) begin
            o_status       <= r_stat;
            o_value_out    <= vout_x[VAL_W-1:0];
            o_best_key     <= best_x[KEY_W-1:0];
            o_prefix_count <= r_pcnt;
        end
    end
endmodule

[hdl/binary_trie_max_xor_unit.sv]
// Insert and erase walk the trie twice, a check pass and then an update pass; get and
// max_xor walk it once and then read the leaf; prefix counting walks down to the prefix
// length, clipped to KEY_BITS. A miss or a full pool ends the walk early. One trie level
// per cycle, set by the single read port of the node and count memories.
// One item is in work at a time; the unit is ready for the next once the result is
// registered. After reset a clearing pass over all NODE_COUNT rows blocks input.
module binary_trie_max_xor_unit #(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096,
    parameter int VALUE_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    btx_req_if.sink  i_req,
    btx_rsp_if.source o_rsp
);
    import btx_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    btx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    btx_dp #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_req.action),
        .i_key          (i_req.key),
        .i_value_in     (i_req.value_in),
        .i_prefix_len   (i_req.prefix_len),
        .o_status       (o_rsp.status),
        .o_value_out    (o_rsp.value_out),
        .o_best_key     (o_rsp.best_key),
        .o_prefix_count (o_rsp.prefix_count)
    );
endmodule

[verif/tb_binary_trie_max_xor_unit.sv]
// Self-checking testbench for the binary trie max-xor unit: directed and random actions.
`timescale 1ns / 1ps

module tb_binary_trie_max_xor_unit;
    import btx_pkg::*;

    localparam int NODES     = 4096;
    localparam int WDOG_MAX  = 20000;
    localparam int TAIL_WAIT = 200;

    typedef struct {
        t_status          status;
        logic [VAL_W-1:0] value_out;
        logic [KEY_W-1:0] best_key;
        logic [CNT_W-1:0] prefix_count;
    } t_trie_result;

    logic i_clk;
    logic i_rst_n;

    btx_req_if req_if();
    btx_rsp_if rsp_if();

    binary_trie_max_xor_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow trie
    int unsigned      node_link [0:2*NODES-1];
    int unsigned      edge_cnt  [0:2*NODES-1];
    logic [VAL_W-1:0] leaf_val  [0:NODES-1];
    int unsigned      next_node;

    t_trie_result     pending_results[$];
    logic [KEY_W-1:0] key_pool[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int items_sent;
    int results_seen;
    int full_seen;
    int miss_seen;
    int quiet_cycles;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int unsigned edge_slot(int unsigned node, logic b);
        return node * 2 + int'(b);
    endfunction

    // Apply one action to the shadow trie and return its result
    function automatic t_trie_result trie_apply(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                                logic [VAL_W-1:0] v, logic [PLEN_W-1:0] plen);
        t_trie_result r;
        int unsigned node;
        int unsigned s;
        int unsigned so;
        int unsigned nxt;
        int unsigned need;
        int unsigned sum;
        int unsigned n;
        logic missing;
        logic found;
        logic [KEY_W-1:0] acc;
        r = '{ST_OK, '0, '0, '0};
        node = 0;
        found = 1'b1;
        case (act)
            ACT_INSERT: begin
                need = 0;
                missing = 1'b0;
                for (int i = KEY_W-1; i >= 0; i--) begin
                    s = edge_slot(node, k[i]);
                    if (missing || node_link[s] == 0) begin
                        missing = 1'b1;
                        need++;
                    end else begin
                        node = node_link[s];
                    end
                end
                if (next_node + need > NODES) begin
                    r.status = ST_FULL;
                end else begin
                    node = 0;
                    for (int i = KEY_W-1; i >= 0; i--) begin
                        s = edge_slot(node, k[i]);
                        if (node_link[s] == 0) begin
                            node_link[s] = next_node;
                            next_node++;
                        end
                        if (edge_cnt[s] < CNT_MAX) edge_cnt[s]++;
                        node = node_link[s];
                    end
                    leaf_val[node] = v;
                end
            end
            ACT_ERASE, ACT_GET: begin
                for (int i = KEY_W-1; i >= 0 && found; i--) begin
                    s = edge_slot(node, k[i]);
                    if (node_link[s] == 0) found = 1'b0;
                    else node = node_link[s];
                end
                if (!found) begin
                    r.status = ST_MISS;
                end else if (act == ACT_GET) begin
                    r.value_out = leaf_val[node];
                end else begin
                    // Decrement the whole path, unlink edges that drop to zero
                    node = 0;
                    for (int i = KEY_W-1; i >= 0; i--) begin
                        s = edge_slot(node, k[i]);
                        nxt = node_link[s];
                        if (edge_cnt[s] > 0) edge_cnt[s]--;
                        if (edge_cnt[s] == 0) begin
                            node_link[s] = 0;
                            if (i == 0) leaf_val[nxt] = '0;
                        end
                        node = nxt;
                    end
                end
            end
            ACT_COUNT: begin
                n = (plen > KEY_W) ? KEY_W : plen;
                if (n == 0) begin
                    sum = edge_cnt[0] + edge_cnt[1];
                    r.prefix_count = (sum > CNT_MAX) ? CNT_MAX : sum[CNT_W-1:0];
                end else begin
                    sum = 0;
                    for (int j = 0; j < n; j++) begin
                        s = edge_slot(node, k[KEY_W-1-j]);
                        if (node_link[s] == 0) begin
                            sum = 0;
                            break;
                        end
                        sum = edge_cnt[s];
                        node = node_link[s];
                    end
                    r.prefix_count = sum[CNT_W-1:0];
                end
            end
            ACT_MAXX: begin
                acc = '0;
                for (int i = KEY_W-1; i >= 0 && found; i--) begin
                    so = edge_slot(node, ~k[i]);
                    s  = edge_slot(node, k[i]);
                    if (node_link[so] != 0) begin
                        node = node_link[so];
                        acc[i] = ~k[i];
                    end else if (node_link[s] != 0) begin
                        node = node_link[s];
                        acc[i] = k[i];
                    end else begin
                        found = 1'b0;
                    end
                end
                if (found) begin
                    r.best_key  = acc;
                    r.value_out = leaf_val[node];
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one item, predict its result once it is accepted
    task automatic send_action(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                               logic [VAL_W-1:0] v, logic [PLEN_W-1:0] plen);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.key        <= k;
        req_if.value_in   <= v;
        req_if.prefix_len <= plen;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_results.push_back(trie_apply(act, k, v, plen));
        items_sent++;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    // Check results and drive the receiver stall
    always @(posedge i_clk) begin
        t_trie_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", rsp_if.status, 0);
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status != want.status)
                    report_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.value_out != want.value_out)
                    report_mismatch("value_out", rsp_if.value_out, want.value_out);
                if (rsp_if.best_key != want.best_key)
                    report_mismatch("best_key", rsp_if.best_key, want.best_key);
                if (rsp_if.prefix_count != want.prefix_count)
                    report_mismatch("prefix_count", rsp_if.prefix_count, want.prefix_count);
                if (want.status == ST_FULL) full_seen++;
                if (want.status == ST_MISS) miss_seen++;
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no accepted item on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("watchdog expired after %0d idle cycles", WDOG_MAX);
            $display("** binary_trie_max_xor_unit: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 12 || key_pool.size() == 0)
            return $urandom();
        return key_pool[$urandom_range(key_pool.size()-1)];
    endfunction

    // Edges of the key space, duplicates, erase down to zero, unused actions
    task automatic test_directed();
        send_action(ACT_MAXX, 32'h1234_5678, '0, 6'd0);
        send_action(ACT_GET, 32'h0, '0, 6'd0);
        send_action(ACT_ERASE, 32'h0, '0, 6'd0);
        send_action(ACT_COUNT, 32'h0, '0, 6'd0);
        send_action(ACT_INSERT, 32'h0, 32'hFFFF_FFFF, 6'd0);
        send_action(ACT_INSERT, 32'hFFFF_FFFF, 32'h0, 6'd0);
        send_action(ACT_INSERT, 32'h0, 32'h0000_0005, 6'd0);
        send_action(ACT_GET, 32'h0, '0, 6'd0);
        send_action(ACT_COUNT, 32'h0, '0, 6'd0);
        send_action(ACT_COUNT, 32'h0, '0, 6'd32);
        send_action(ACT_COUNT, 32'hFFFF_FFFF, '0, 6'd63);
        send_action(ACT_COUNT, 32'h0, '0, 6'd40);
        send_action(ACT_COUNT, 32'h7FFF_FFFF, '0, 6'd1);
        send_action(ACT_COUNT, 32'h8000_0000, '0, 6'd2);
        send_action(ACT_MAXX, 32'h0, '0, 6'd0);
        send_action(ACT_MAXX, 32'hFFFF_FFFF, '0, 6'd0);
        send_action(ACT_ERASE, 32'h0, '0, 6'd0);
        send_action(ACT_GET, 32'h0, '0, 6'd0);
        send_action(ACT_ERASE, 32'h0, '0, 6'd0);
        send_action(ACT_GET, 32'h0, '0, 6'd0);
        send_action(ACT_ERASE, 32'h0, '0, 6'd0);
        for (int a = int'(ACT_MAXX) + 1; a < 8; a++)
            send_action(a[ACT_W-1:0], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_action(ACT_MAXX, 32'hFFFF_FFFF, '0, 6'd0);
    endtask

    // Random mix over a pool of related keys, mostly well-formed actions
    task automatic test_random(int n, int idle_pct, int stall_pct);
        logic [ACT_W-1:0] act;
        logic [PLEN_W-1:0] plen;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            act = ACT_W'(($urandom_range(99) < 4) ? $urandom_range(5, 7) : $urandom_range(0, 4));
            plen = PLEN_W'(($urandom_range(99) < 85) ? $urandom_range(0, 32)
                                                     : $urandom_range(33, 63));
            send_action(act, pick_key(), $urandom(), plen);
        end
        wait_drained();
    endtask

    // Hold off the sender until every result is back, then resume
    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 59;
        for (int i = 0; i < 3; i++) send_action(ACT_INSERT, pick_key(), $urandom(), 6'd0);
        wait_drained();
        send_action(ACT_MAXX, $urandom(), '0, 6'd0);
        send_action(ACT_COUNT, pick_key(), '0, 6'd16);
        wait_drained();
    endtask

    initial begin
        logic [KEY_W-1:0] base;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.action = ACT_INSERT;
        req_if.key = '0;
        req_if.value_in = '0;
        req_if.prefix_len = '0;
        rsp_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        full_seen = 0;
        miss_seen = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 2*NODES; i++) begin
            node_link[i] = 0;
            edge_cnt[i] = 0;
        end
        for (int i = 0; i < NODES; i++) leaf_val[i] = '0;
        next_node = 1;
        // Related keys: a few shared high parts with varied low bits
        for (int g = 0; g < 6; g++) begin
            base = $urandom();
            for (int j = 0; j < 5; j++) key_pool.push_back(base ^ ($urandom() >> $urandom_range(4, 28)));
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_drained();
        test_random(110, 0, 0);
        test_drain_pause();
        test_random(110, 59, 0);
        test_random(110, 0, 59);
        test_random(110, 26, 26);

        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("covered %0d items: %0d not-found and %0d pool-full results, nodes used %0d",
                 items_sent, miss_seen, full_seen, next_node);
        $display("phases: directed, no idling, sender idle, receiver stall, both, drain pause");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** binary_trie_max_xor_unit: PASSED **");
        end else begin
            $display("** binary_trie_max_xor_unit: FAILED **");
        end
        $finish;
    end

endmodule

[binary_trie_max_xor_unit.f]
hdl/btx_pkg.sv
hdl/btx_req_if.sv
hdl/btx_rsp_if.sv
hdl/btx_ram.sv
hdl/btx_ctrl.sv
hdl/btx_dp.sv
hdl/binary_trie_max_xor_unit.sv
verif/tb_binary_trie_max_xor_unit.sv
